// File: hw/rtl/mscp_pkg.sv
// ----------------------------------------------------------------------------
// mscp_pkg
// Shared types and constants of the motor and steering command line parser.
// ----------------------------------------------------------------------------
package mscp_pkg;

    localparam int LINE_BYTES_DEF = 64;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int MAG_W     = 16;
    localparam int VAL_W     = MAG_W + 1;
    localparam int S_DATA_W  = 8;
    localparam int M_DATA_W  = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEER_LOW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEER_HIGH = 2'd3;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_S     = 8'h53;

    localparam logic [MAG_W-1:0] MAG_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        OP_PARSE,
        OP_TEXT_END,
        OP_CLEAR,
        OP_LINE,
        OP_LINE_QUIET
    } op_t;

    typedef enum logic [2:0] {
        CL_SPACE,
        CL_WS,
        CL_PLUS,
        CL_MINUS,
        CL_DIGIT,
        CL_KEY_M,
        CL_KEY_S,
        CL_OTHER
    } cls_t;

    typedef struct packed {
        op_t        op;
        cls_t       cls;
        logic [3:0] digit;
    } item_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_MISSING,
        ST_MOTOR_RANGE,
        ST_STEER_RANGE
    } status_t;

    typedef struct packed {
        logic signed [CFG_W-1:0] motor_low;
        logic signed [CFG_W-1:0] motor_high;
        logic signed [CFG_W-1:0] steer_low;
        logic signed [CFG_W-1:0] steer_high;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        motor_low:  16'sd1000,
        motor_high: 16'sd2000,
        steer_low:  16'sd1000,
        steer_high: 16'sd2000
    };

endpackage

// File: hw/rtl/mscp_front.sv
// ----------------------------------------------------------------------------
// mscp_front
// Byte intake: tracks line length and end of text, classifies each byte and
// pushes a parse, text-end, line or clear operation into the queue.
// ----------------------------------------------------------------------------
module mscp_front
    import mscp_pkg::*;
#(
    parameter int LINE_BYTES = LINE_BYTES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    input  logic [7:0]   in_byte,
    output logic         in_ready,
    input  logic         q_full,
    output logic         push_valid,
    output item_t        push_item
);

    localparam int LEN_W = $clog2(LINE_BYTES);
    localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(LINE_BYTES - 1);

    logic [LEN_W-1:0] len_reg, len_next;
    logic             ended_reg, ended_next;
    logic             accept;
    cls_t             cls;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;

    always_comb begin
        priority if (in_byte == CH_SPACE) begin
            cls = CL_SPACE;
        end else if (in_byte == CH_TAB || in_byte == CH_VT || in_byte == CH_FF) begin
            cls = CL_WS;
        end else if (in_byte == CH_PLUS) begin
            cls = CL_PLUS;
        end else if (in_byte == CH_MINUS) begin
            cls = CL_MINUS;
        end else if (in_byte >= CH_ZERO && in_byte <= CH_NINE) begin
            cls = CL_DIGIT;
        end else if (in_byte == CH_M) begin
            cls = CL_KEY_M;
        end else if (in_byte == CH_S) begin
            cls = CL_KEY_S;
        end else begin
            cls = CL_OTHER;
        end
    end

    always_comb begin
        len_next        = len_reg;
        ended_next      = ended_reg;
        push_valid      = 1'b0;
        push_item.op    = OP_PARSE;
        push_item.cls   = cls;
        push_item.digit = in_byte[3:0];
        if (accept) begin
            priority if (in_byte == CH_NL) begin
                push_valid   = 1'b1;
                push_item.op = ended_reg ? OP_LINE_QUIET : OP_LINE;
                len_next     = '0;
                ended_next   = 1'b0;
            end else if (in_byte == CH_CR) begin
                // carriage return is dropped
            end else if (len_reg == LEN_LAST) begin
                push_valid   = 1'b1;
                push_item.op = OP_CLEAR;
                len_next     = '0;
                ended_next   = 1'b0;
            end else begin
                len_next = len_reg + 1'b1;
                if (!ended_reg) begin
                    push_valid = 1'b1;
                    if (in_byte == CH_NUL) begin
                        push_item.op = OP_TEXT_END;
                        ended_next   = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg   <= '0;
            ended_reg <= 1'b0;
        end else begin
            len_reg   <= len_next;
            ended_reg <= ended_next;
        end
    end

endmodule

// File: hw/rtl/mscp_queue.sv
// ----------------------------------------------------------------------------
// mscp_queue
// Short first-in first-out queue of parse operations between intake and
// parser.
// ----------------------------------------------------------------------------
module mscp_queue
    import mscp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  item_t             push_item,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output item_t             head_item,
    output logic [QCNT_W-1:0] count
);

    item_t             mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem[rd_ptr_reg];
    assign count      = count_reg;
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/mscp_back.sv
// ----------------------------------------------------------------------------
// mscp_back
// Token and number parser: carries out queued operations, keeps the found
// values and issues one result per line into the output register.
// ----------------------------------------------------------------------------
module mscp_back
    import mscp_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cfg_t                    cfg,
    input  logic                    head_valid,
    input  item_t                   head_item,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output status_t                 out_status,
    output logic signed [CFG_W-1:0] out_motor,
    output logic signed [CFG_W-1:0] out_steer
);

    typedef enum logic [2:0] {
        TP_KEYWAIT,
        TP_INKEY,
        TP_MWAIT,
        TP_SWAIT,
        TP_INMVAL,
        TP_INSVAL
    } tp_t;

    typedef enum logic [1:0] {
        NP_SKIP,
        NP_SIGN,
        NP_DIGITS,
        NP_DONE
    } np_t;

    typedef enum logic [1:0] {
        KEY_M,
        KEY_S,
        KEY_OTHER
    } key_t;

    tp_t                     tp_reg, tp_next;
    key_t                    key_reg, key_next;
    logic                    key_long_reg, key_long_next;
    np_t                     np_reg, np_next;
    logic                    neg_reg, neg_next;
    logic [MAG_W-1:0]        mag_reg, mag_next;
    logic                    mfound_reg, mfound_next;
    logic                    sfound_reg, sfound_next;
    logic signed [VAL_W-1:0] mval_reg, mval_next;
    logic signed [VAL_W-1:0] sval_reg, sval_next;
    logic                    ovalid_reg, ovalid_next;
    status_t                 ostatus_reg, ostatus_next;
    logic signed [CFG_W-1:0] omotor_reg, omotor_next;
    logic signed [CFG_W-1:0] osteer_reg, osteer_next;

    // end of token
    tp_t                     et_tp;
    logic signed [VAL_W-1:0] et_mval, et_sval;
    logic signed [VAL_W-1:0] cur_val;

    // number digit step
    np_t                     nb_ph_in, nb_ph;
    logic                    nb_neg_in, nb_neg;
    logic [MAG_W-1:0]        nb_mag_in, nb_mag;
    logic [MAG_W+3:0]        mag_x10;
    logic                    is_digit;

    logic                    is_line, out_free;
    logic signed [VAL_W-1:0] line_mval, line_sval;
    logic signed [VAL_W-1:0] m_lo, m_hi, s_lo, s_hi;
    status_t                 line_status;

    assign out_free = !ovalid_reg || out_ready;
    assign is_line  = (head_item.op == OP_LINE) || (head_item.op == OP_LINE_QUIET);
    assign pop      = head_valid && (!is_line || out_free);

    assign cur_val = neg_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});

    always_comb begin
        et_tp   = tp_reg;
        et_mval = mval_reg;
        et_sval = sval_reg;
        unique case (tp_reg)
            TP_INKEY: begin
                if (!key_long_reg && key_reg == KEY_M) begin
                    et_tp = TP_MWAIT;
                end else if (!key_long_reg && key_reg == KEY_S) begin
                    et_tp = TP_SWAIT;
                end else begin
                    et_tp = TP_KEYWAIT;
                end
            end
            TP_INMVAL: begin
                et_mval = cur_val;
                et_tp   = TP_KEYWAIT;
            end
            TP_INSVAL: begin
                et_sval = cur_val;
                et_tp   = TP_KEYWAIT;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (tp_reg == TP_MWAIT || tp_reg == TP_SWAIT) begin
            nb_ph_in  = NP_SKIP;
            nb_neg_in = 1'b0;
            nb_mag_in = '0;
        end else begin
            nb_ph_in  = np_reg;
            nb_neg_in = neg_reg;
            nb_mag_in = mag_reg;
        end
        is_digit = (head_item.cls == CL_DIGIT);
        mag_x10  = ({4'b0, nb_mag_in} << 3) + ({4'b0, nb_mag_in} << 1)
                 + {{MAG_W{1'b0}}, head_item.digit};
        nb_ph    = nb_ph_in;
        nb_neg   = nb_neg_in;
        nb_mag   = nb_mag_in;
        unique case (nb_ph_in)
            NP_SKIP: begin
                priority if (head_item.cls == CL_WS) begin
                    nb_ph = NP_SKIP;
                end else if (head_item.cls == CL_PLUS || head_item.cls == CL_MINUS) begin
                    nb_neg = (head_item.cls == CL_MINUS);
                    nb_ph  = NP_SIGN;
                end else if (is_digit) begin
                    nb_mag = {{(MAG_W-4){1'b0}}, head_item.digit};
                    nb_ph  = NP_DIGITS;
                end else begin
                    nb_ph = NP_DONE;
                end
            end
            NP_SIGN: begin
                if (is_digit) begin
                    nb_mag = {{(MAG_W-4){1'b0}}, head_item.digit};
                    nb_ph  = NP_DIGITS;
                end else begin
                    nb_ph = NP_DONE;
                end
            end
            NP_DIGITS: begin
                if (is_digit) begin
                    nb_mag = (mag_x10 > {4'b0, MAG_MAX}) ? MAG_MAX : mag_x10[MAG_W-1:0];
                end else begin
                    nb_ph = NP_DONE;
                end
            end
            NP_DONE: begin
                nb_ph = NP_DONE;
            end
        endcase
    end

    // range check at end of line
    always_comb begin
        line_mval = (head_item.op == OP_LINE) ? et_mval : mval_reg;
        line_sval = (head_item.op == OP_LINE) ? et_sval : sval_reg;
        m_lo = $signed({cfg.motor_low[CFG_W-1], cfg.motor_low});
        m_hi = $signed({cfg.motor_high[CFG_W-1], cfg.motor_high});
        s_lo = $signed({cfg.steer_low[CFG_W-1], cfg.steer_low});
        s_hi = $signed({cfg.steer_high[CFG_W-1], cfg.steer_high});
        priority if (!(mfound_reg && sfound_reg)) begin
            line_status = ST_MISSING;
        end else if (line_mval < m_lo || line_mval > m_hi) begin
            line_status = ST_MOTOR_RANGE;
        end else if (line_sval < s_lo || line_sval > s_hi) begin
            line_status = ST_STEER_RANGE;
        end else begin
            line_status = ST_OK;
        end
    end

    always_comb begin
        tp_next       = tp_reg;
        key_next      = key_reg;
        key_long_next = key_long_reg;
        np_next       = np_reg;
        neg_next      = neg_reg;
        mag_next      = mag_reg;
        mfound_next   = mfound_reg;
        sfound_next   = sfound_reg;
        mval_next     = mval_reg;
        sval_next     = sval_reg;
        ovalid_next   = ovalid_reg && !out_ready;
        ostatus_next  = ostatus_reg;
        omotor_next   = omotor_reg;
        osteer_next   = osteer_reg;

        if (pop) begin
            unique case (head_item.op)
                OP_PARSE: begin
                    if (head_item.cls == CL_SPACE) begin
                        tp_next   = et_tp;
                        mval_next = et_mval;
                        sval_next = et_sval;
                    end else begin
                        unique case (tp_reg)
                            TP_KEYWAIT: begin
                                tp_next       = TP_INKEY;
                                key_long_next = 1'b0;
                                if (head_item.cls == CL_KEY_M) begin
                                    key_next = KEY_M;
                                end else if (head_item.cls == CL_KEY_S) begin
                                    key_next = KEY_S;
                                end else begin
                                    key_next = KEY_OTHER;
                                end
                            end
                            TP_INKEY: begin
                                key_long_next = 1'b1;
                            end
                            TP_MWAIT: begin
                                mfound_next = 1'b1;
                                tp_next     = TP_INMVAL;
                                np_next     = nb_ph;
                                neg_next    = nb_neg;
                                mag_next    = nb_mag;
                            end
                            TP_SWAIT: begin
                                sfound_next = 1'b1;
                                tp_next     = TP_INSVAL;
                                np_next     = nb_ph;
                                neg_next    = nb_neg;
                                mag_next    = nb_mag;
                            end
                            default: begin
                                np_next  = nb_ph;
                                neg_next = nb_neg;
                                mag_next = nb_mag;
                            end
                        endcase
                    end
                end
                OP_TEXT_END: begin
                    tp_next   = et_tp;
                    mval_next = et_mval;
                    sval_next = et_sval;
                end
                default: begin
                    // clear on overflow and after every line
                    tp_next       = TP_KEYWAIT;
                    key_next      = KEY_OTHER;
                    key_long_next = 1'b0;
                    np_next       = NP_SKIP;
                    neg_next      = 1'b0;
                    mag_next      = '0;
                    mfound_next   = 1'b0;
                    sfound_next   = 1'b0;
                    mval_next     = '0;
                    sval_next     = '0;
                    if (is_line) begin
                        ovalid_next  = 1'b1;
                        ostatus_next = line_status;
                        omotor_next  = (line_status == ST_OK) ? line_mval[CFG_W-1:0] : '0;
                        osteer_next  = (line_status == ST_OK) ? line_sval[CFG_W-1:0] : '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tp_reg       <= TP_KEYWAIT;
            key_reg      <= KEY_OTHER;
            key_long_reg <= 1'b0;
            np_reg       <= NP_SKIP;
            neg_reg      <= 1'b0;
            mag_reg      <= '0;
            mfound_reg   <= 1'b0;
            sfound_reg   <= 1'b0;
            mval_reg     <= '0;
            sval_reg     <= '0;
            ovalid_reg   <= 1'b0;
        end else begin
            tp_reg       <= tp_next;
            key_reg      <= key_next;
            key_long_reg <= key_long_next;
            np_reg       <= np_next;
            neg_reg      <= neg_next;
            mag_reg      <= mag_next;
            mfound_reg   <= mfound_next;
            sfound_reg   <= sfound_next;
            mval_reg     <= mval_next;
            sval_reg     <= sval_next;
            ovalid_reg   <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ostatus_reg <= ostatus_next;
        omotor_reg  <= omotor_next;
        osteer_reg  <= osteer_next;
    end

    assign out_valid  = ovalid_reg;
    assign out_status = ostatus_reg;
    assign out_motor  = omotor_reg;
    assign out_steer  = osteer_reg;

endmodule

// File: hw/rtl/motor_steer_command_line_parser.sv
// ----------------------------------------------------------------------------
// motor_steer_command_line_parser
// Parses text lines of "M <value> S <value>" style commands from a byte
// stream, checks both values against configurable limits and reports one
// result per newline.
//
//   channel   direction  tdata fields (lowest bit up)
//   s_        in         rx_byte[7:0]
//   m_        out        status[1:0], motor[17:2], steer[33:18], zero pad
//   cfg_      in         write enable, register index, 16-bit data
//
// One byte per cycle is taken while the queue has room; the parser retires
// one queued operation per cycle, so the sustained rate is one byte a cycle.
// With the queue empty, a newline's result is registered first in the queue
// entry and then in the output register before it shows on m_. Only a
// newline waiting on a full, stalled output register holds the parser; the
// two-entry queue then fills and s_tready falls. Reset is synchronous, clears
// the line state and queue and sets the limits to their reset values.
// ----------------------------------------------------------------------------
module motor_steer_command_line_parser
    import mscp_pkg::*;
#(
    parameter int LINE_BYTES = LINE_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // rx_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // status, motor, steer
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wr_data
);

    cfg_t                    cfg_reg;
    logic                    push_valid, q_full, pop, head_valid;
    item_t                   push_item, head_item;
    logic [QCNT_W-1:0]       q_count;
    status_t                 out_status;
    logic signed [CFG_W-1:0] out_motor, out_steer;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_MOTOR_LOW:  cfg_reg.motor_low  <= cfg_wr_data;
                CFG_MOTOR_HIGH: cfg_reg.motor_high <= cfg_wr_data;
                CFG_STEER_LOW:  cfg_reg.steer_low  <= cfg_wr_data;
                CFG_STEER_HIGH: cfg_reg.steer_high <= cfg_wr_data;
            endcase
        end
    end

    mscp_front #(
        .LINE_BYTES(LINE_BYTES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_byte   (s_tdata),
        .in_ready  (s_tready),
        .q_full    (q_full),
        .push_valid(push_valid),
        .push_item (push_item)
    );

    mscp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push_valid),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .head_valid(head_valid),
        .head_item (head_item),
        .count     (q_count)
    );

    mscp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .head_valid(head_valid),
        .head_item (head_item),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_status(out_status),
        .out_motor (out_motor),
        .out_steer (out_steer)
    );

    assign m_tdata = {6'b0, out_steer, out_motor, out_status};

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue fill above depth");

    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_status != ST_OK |-> out_motor == '0 && out_steer == '0)
        else $error("rejected transaction carries values");

    a_accept_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_status == ST_OK |->
            out_motor >= cfg_reg.motor_low && out_motor <= cfg_reg.motor_high &&
            out_steer >= cfg_reg.steer_low && out_steer <= cfg_reg.steer_high)
        else $error("accepted transaction outside limits");

    a_line_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        head_valid && m_tvalid && !m_tready &&
        (head_item.op == OP_LINE || head_item.op == OP_LINE_QUIET) |-> !pop)
        else $error("result overwritten while stalled");

endmodule
